@@ rtl/acp_pkg.sv @@
package acp_pkg;

    localparam int KEY_SLOTS = 3;
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 4;

    localparam logic [15:0] MULT_DEFAULT = 16'd52845;
    localparam logic [15:0] ADD_DEFAULT  = 16'd22719;
    localparam logic [KEY_SLOTS-1:0][15:0] KEY_DEFAULTS = {16'd21354, 16'd42536, 16'd62153};

    localparam logic [7:0] LETTER_BASE = 8'd65;
    localparam logic [7:0] RADIX       = 8'd26;
    localparam logic [7:0] LETTER_P    = 8'd80;
    localparam logic [7:0] LETTER_C    = 8'd67;
    // (65 * 26 + 65) mod 256: letter offsets folded into one constant
    localparam logic [7:0] PAIR_OFFSET = 8'd219;
    // floor(c / 26) == (c * 79) >> 11 for every 8-bit c
    localparam logic [6:0] RECIP_26    = 7'd79;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_message;
    } request_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       last_out;
        logic       no_data;
    } result_t;

    typedef struct packed {
        logic       decrypt;
        logic       eom;
        logic [7:0] data;
    } cmd_t;

    typedef struct packed {
        logic [15:0]                  mult_const;
        logic [15:0]                  add_const;
        logic [KEY_SLOTS-1:0][15:0]   start_key;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ENC,
        ST_DEC
    } eng_state_t;

    typedef enum logic [2:0] {
        REG_MULT,
        REG_ADD,
        REG_KEY0,
        REG_KEY1,
        REG_KEY2,
        REG_DECRYPT
    } reg_index_t;

    function automatic logic [15:0] next_key(input logic [7:0] x, input logic [15:0] k,
                                             input logic [15:0] m, input logic [15:0] a);
        logic [15:0] s;
        logic [31:0] p;
        s = k + {8'd0, x};
        p = s * m;
        return p[15:0] + a;
    endfunction

    function automatic logic [7:0] letter_hi(input logic [7:0] c);
        logic [14:0] p;
        p = c * RECIP_26;
        return LETTER_BASE + {4'd0, p[14:11]};
    endfunction

    function automatic logic [7:0] letter_lo(input logic [7:0] c);
        logic [14:0] p;
        logic [7:0]  q;
        p = c * RECIP_26;
        q = {4'd0, p[14:11]};
        return LETTER_BASE + (c - 8'(q * RADIX));
    endfunction

    function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
        return 8'(hi * RADIX) + lo - PAIR_OFFSET;
    endfunction

endpackage

@@ rtl/autokey_letter_pair_cipher_core.sv @@
// channel   | handshake       | payload                                  | dir
// request   | push / full     | data_in[7:0], end_of_message             | in
// result    | pop / empty     | data_out[7:0], last_out, no_data         | out
// config    | psel/penable    | paddr[4:0], pwdata, prdata (APB)         | in/out
//
// Encrypt: one layer step or one held low letter per cycle while the result queue has room;
//   each byte is taken, run through every layer and finished before the next is taken.
//   The closing byte adds the "PC" trailer feeds into every layer.
// Decrypt: one layer per cycle while the result queue has room.
// Reset (rst_n low, async) loads default constants and keys; no clearing pass.
// A full result queue stalls the engine only; the input queue takes items until it fills.
module autokey_letter_pair_cipher_core #(
    parameter int LAYER_COUNT = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    // input queue side
    input  logic              push,
    output logic              full,
    input  acp_pkg::request_t request,
    // result queue side
    output logic              empty,
    input  logic              pop,
    output acp_pkg::result_t  result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [15:0] mult_reg, mult_next;
    logic [15:0] add_reg, add_next;
    logic [acp_pkg::KEY_SLOTS-1:0][15:0] key_reg, key_next;
    logic        dec_reg, dec_next;

    logic             cfg_wr;
    logic [2:0]       cfg_idx;
    acp_pkg::cfg_t    cfg;
    acp_pkg::cmd_t    cmd;
    logic             cmd_empty, cmd_pop;
    logic             res_full, res_push;
    acp_pkg::result_t res_item;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Register writes: zero on the constant registers selects the default.
    // Every write, decoded or not, restarts the message in progress.
    always_comb
    begin
        mult_next = mult_reg;
        add_next  = add_reg;
        key_next  = key_reg;
        dec_next  = dec_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                acp_pkg::REG_MULT:
                    mult_next = (pwdata[15:0] == '0) ? acp_pkg::MULT_DEFAULT : pwdata[15:0];
                acp_pkg::REG_ADD:
                    add_next = (pwdata[15:0] == '0) ? acp_pkg::ADD_DEFAULT : pwdata[15:0];
                acp_pkg::REG_KEY0:    key_next[0] = pwdata[15:0];
                acp_pkg::REG_KEY1:    key_next[1] = pwdata[15:0];
                acp_pkg::REG_KEY2:    key_next[2] = pwdata[15:0];
                acp_pkg::REG_DECRYPT: dec_next    = pwdata[0];
                default:              dec_next    = dec_reg;
            endcase
        end
    end

    // Read back the stored values.
    always_comb
    begin
        case (cfg_idx)
            acp_pkg::REG_MULT:    prdata = {16'd0, mult_reg};
            acp_pkg::REG_ADD:     prdata = {16'd0, add_reg};
            acp_pkg::REG_KEY0:    prdata = {16'd0, key_reg[0]};
            acp_pkg::REG_KEY1:    prdata = {16'd0, key_reg[1]};
            acp_pkg::REG_KEY2:    prdata = {16'd0, key_reg[2]};
            acp_pkg::REG_DECRYPT: prdata = {31'd0, dec_reg};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mult_reg <= acp_pkg::MULT_DEFAULT;
            add_reg  <= acp_pkg::ADD_DEFAULT;
            key_reg  <= acp_pkg::KEY_DEFAULTS;
            dec_reg  <= 1'b0;
        end
        else
        begin
            mult_reg <= mult_next;
            add_reg  <= add_next;
            key_reg  <= key_next;
            dec_reg  <= dec_next;
        end
    end

    // Feed the engine the values as they stand after this cycle's write.
    always_comb
    begin
        cfg.mult_const = mult_next;
        cfg.add_const  = add_next;
        cfg.start_key  = key_next;
    end

    // Front: accept items, tag with mode, queue them.
    acp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .request     (request),
        .decrypt_mode(dec_reg),
        .cmd_pop     (cmd_pop),
        .cmd         (cmd),
        .cmd_empty   (cmd_empty)
    );

    // Back: run the layers one step per cycle while the result queue has room.
    acp_back #(
        .LAYER_COUNT(LAYER_COUNT)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_restart(cfg_wr),
        .cmd        (cmd),
        .cmd_empty  (cmd_empty),
        .cmd_pop    (cmd_pop),
        .res_full   (res_full),
        .res_push   (res_push),
        .res_item   (res_item)
    );

    // Hold finished items until the consumer takes them.
    acp_fifo #(
        .WIDTH($bits(acp_pkg::result_t)),
        .DEPTH(acp_pkg::RES_DEPTH)
    ) u_res_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (res_push),
        .wr_data(res_item),
        .rd_en  (pop),
        .rd_data(result),
        .full   (res_full),
        .empty  (empty)
    );

endmodule

@@ rtl/acp_fifo.sv @@
module acp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ rtl/acp_front.sv @@
module acp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  acp_pkg::request_t request,
    input  logic              decrypt_mode,
    input  logic              cmd_pop,
    output acp_pkg::cmd_t     cmd,
    output logic              cmd_empty
);

    acp_pkg::cmd_t cmd_in;

    // tag each item with the mode it arrived under
    always_comb
    begin
        cmd_in.decrypt = decrypt_mode;
        cmd_in.eom     = request.end_of_message;
        cmd_in.data    = request.data_in;
    end

    acp_fifo #(
        .WIDTH($bits(acp_pkg::cmd_t)),
        .DEPTH(acp_pkg::CMD_DEPTH)
    ) u_cmd_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (push),
        .wr_data(cmd_in),
        .rd_en  (cmd_pop),
        .rd_data(cmd),
        .full   (full),
        .empty  (cmd_empty)
    );

endmodule

@@ rtl/acp_back.sv @@
module acp_back #(
    parameter int LAYER_COUNT = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  acp_pkg::cfg_t    cfg,
    input  logic             cfg_restart,
    input  acp_pkg::cmd_t    cmd,
    input  logic             cmd_empty,
    output logic             cmd_pop,
    input  logic             res_full,
    output logic             res_push,
    output acp_pkg::result_t res_item
);

    localparam int LW = (LAYER_COUNT > 1) ? $clog2(LAYER_COUNT) : 1;
    localparam int FW = $clog2(2 * LAYER_COUNT + 1);
    localparam logic [LW-1:0] LAST_LAYER = LW'(LAYER_COUNT - 1);
    localparam logic [FW-1:0] FEED_LAST  = FW'(2 * LAYER_COUNT);

    acp_pkg::eng_state_t state_reg, state_next;
    acp_pkg::cmd_t       cmd_reg, cmd_next;
    logic [FW-1:0]       feed_reg, feed_next;
    logic                cur_valid_reg, cur_valid_next;
    logic [LW-1:0]       cur_layer_reg, cur_layer_next;
    logic [7:0]          cur_byte_reg, cur_byte_next;

    logic [LAYER_COUNT-1:0]  pend_reg, pend_next;
    logic [7:0]              pend_byte_reg [LAYER_COUNT];
    logic [7:0]              pend_byte_next [LAYER_COUNT];
    logic [15:0]             key_reg [LAYER_COUNT];
    logic [15:0]             key_next [LAYER_COUNT];
    logic [7:0]              ph_reg [LAYER_COUNT];
    logic [7:0]              ph_next [LAYER_COUNT];
    logic [LAYER_COUNT-1:0]  pp_reg, pp_next;
    logic [1:0]              hcnt_reg [LAYER_COUNT];
    logic [1:0]              hcnt_next [LAYER_COUNT];
    logic [7:0]              hb0_reg [LAYER_COUNT];
    logic [7:0]              hb0_next [LAYER_COUNT];
    logic [7:0]              hb1_reg [LAYER_COUNT];
    logic [7:0]              hb1_next [LAYER_COUNT];

    logic [15:0] sel_key;
    logic [7:0]  enc_c, dec_j, dec_p, key_x, let_hi, let_lo;
    logic [15:0] new_key;
    logic [LW-1:0] deep;
    logic        pend_any;
    logic [1:0]  pend_cnt;
    logic        restart, dec_done;

    // one shared key update per cycle, at the layer under work, while the result queue has room
    always_comb
    begin
        sel_key = key_reg[cur_layer_reg];
        enc_c   = cur_byte_reg ^ sel_key[15:8];
        dec_j   = acp_pkg::pair_value(ph_reg[cur_layer_reg], cur_byte_reg);
        dec_p   = dec_j ^ sel_key[15:8];
        key_x   = (state_reg == acp_pkg::ST_DEC) ? dec_j : enc_c;
        new_key = acp_pkg::next_key(key_x, sel_key, cfg.mult_const, cfg.add_const);
        let_hi  = acp_pkg::letter_hi(enc_c);
        let_lo  = acp_pkg::letter_lo(enc_c);
    end

    // deepest waiting low letter goes next
    always_comb
    begin
        deep     = '0;
        pend_any = 1'b0;
        pend_cnt = '0;
        for (int l = 0; l < LAYER_COUNT; l++)
        begin
            if (pend_reg[l])
            begin
                deep     = LW'(l);
                pend_any = 1'b1;
                pend_cnt = pend_cnt + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        feed_next      = feed_reg;
        cur_valid_next = cur_valid_reg;
        cur_layer_next = cur_layer_reg;
        cur_byte_next  = cur_byte_reg;
        pend_next      = pend_reg;
        pp_next        = pp_reg;
        pend_byte_next = pend_byte_reg;
        key_next       = key_reg;
        ph_next        = ph_reg;
        hcnt_next      = hcnt_reg;
        hb0_next       = hb0_reg;
        hb1_next       = hb1_reg;
        cmd_pop        = 1'b0;
        res_push       = 1'b0;
        res_item       = '0;
        restart        = 1'b0;
        dec_done       = 1'b0;

        case (state_reg)
            acp_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop        = 1'b1;
                    cmd_next       = cmd;
                    feed_next      = '0;
                    cur_byte_next  = cmd.data;
                    cur_valid_next = !cmd.decrypt;
                    cur_layer_next = cmd.decrypt ? LAST_LAYER : '0;
                    state_next     = cmd.decrypt ? acp_pkg::ST_DEC : acp_pkg::ST_ENC;
                end
            end

            acp_pkg::ST_ENC:
            begin
                if (!res_full)
                begin
                    if (cur_valid_reg)
                    begin
                        key_next[cur_layer_reg]       = new_key;
                        pend_next[cur_layer_reg]      = 1'b1;
                        pend_byte_next[cur_layer_reg] = let_lo;
                        if (cur_layer_reg == LAST_LAYER)
                        begin
                            res_push          = 1'b1;
                            res_item.data_out = let_hi;
                            cur_valid_next    = 1'b0;
                        end
                        else
                        begin
                            cur_layer_next = cur_layer_reg + 1'b1;
                            cur_byte_next  = let_hi;
                        end
                    end
                    else if (pend_any)
                    begin
                        pend_next[deep] = 1'b0;
                        if (deep == LAST_LAYER)
                        begin
                            res_push          = 1'b1;
                            res_item.data_out = pend_byte_reg[deep];
                            res_item.last_out = cmd_reg.eom && (feed_reg == FEED_LAST)
                                                && (pend_cnt == 2'd1);
                        end
                        else
                        begin
                            cur_valid_next = 1'b1;
                            cur_layer_next = deep + 1'b1;
                            cur_byte_next  = pend_byte_reg[deep];
                        end
                    end
                    else if (cmd_reg.eom && (feed_reg != FEED_LAST))
                    begin
                        // trailer: "P" then "C" into each layer, innermost first
                        feed_next      = feed_reg + 1'b1;
                        cur_valid_next = 1'b1;
                        cur_layer_next = LW'(feed_reg >> 1);
                        cur_byte_next  = feed_reg[0] ? acp_pkg::LETTER_C : acp_pkg::LETTER_P;
                    end
                    else
                    begin
                        restart    = cmd_reg.eom;
                        state_next = acp_pkg::ST_IDLE;
                    end
                end
            end

            acp_pkg::ST_DEC:
            begin
                if (!res_full)
                begin
                    if (!pp_reg[cur_layer_reg])
                    begin
                        ph_next[cur_layer_reg] = cur_byte_reg;
                        pp_next[cur_layer_reg] = 1'b1;
                        dec_done               = 1'b1;
                    end
                    else
                    begin
                        pp_next[cur_layer_reg]  = 1'b0;
                        key_next[cur_layer_reg] = new_key;
                        if (hcnt_reg[cur_layer_reg] != 2'd2)
                        begin
                            if (hcnt_reg[cur_layer_reg] == 2'd0)
                            begin
                                hb0_next[cur_layer_reg] = dec_p;
                            end
                            else
                            begin
                                hb1_next[cur_layer_reg] = dec_p;
                            end
                            hcnt_next[cur_layer_reg] = hcnt_reg[cur_layer_reg] + 1'b1;
                            dec_done                 = 1'b1;
                        end
                        else
                        begin
                            hb0_next[cur_layer_reg] = hb1_reg[cur_layer_reg];
                            hb1_next[cur_layer_reg] = dec_p;
                            if (cur_layer_reg == '0)
                            begin
                                res_push          = 1'b1;
                                res_item.data_out = hb0_reg[cur_layer_reg];
                                res_item.last_out = cmd_reg.eom;
                                restart           = cmd_reg.eom;
                                state_next        = acp_pkg::ST_IDLE;
                            end
                            else
                            begin
                                cur_layer_next = cur_layer_reg - 1'b1;
                                cur_byte_next  = hb0_reg[cur_layer_reg];
                            end
                        end
                    end
                    if (dec_done)
                    begin
                        res_push          = cmd_reg.eom;
                        res_item.last_out = 1'b1;
                        res_item.no_data  = 1'b1;
                        restart           = cmd_reg.eom;
                        state_next        = acp_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = acp_pkg::ST_IDLE;
            end
        endcase

        if (restart || cfg_restart)
        begin
            pend_next = '0;
            pp_next   = '0;
            for (int l = 0; l < LAYER_COUNT; l++)
            begin
                key_next[l]  = cfg.start_key[l];
                ph_next[l]   = '0;
                hcnt_next[l] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= acp_pkg::ST_IDLE;
            cmd_reg       <= '0;
            feed_reg      <= '0;
            cur_valid_reg <= 1'b0;
            cur_layer_reg <= '0;
            cur_byte_reg  <= '0;
            pend_reg      <= '0;
            pp_reg        <= '0;
            for (int l = 0; l < LAYER_COUNT; l++)
            begin
                key_reg[l]  <= acp_pkg::KEY_DEFAULTS[l];
                ph_reg[l]   <= '0;
                hcnt_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            feed_reg      <= feed_next;
            cur_valid_reg <= cur_valid_next;
            cur_layer_reg <= cur_layer_next;
            cur_byte_reg  <= cur_byte_next;
            pend_reg      <= pend_next;
            pp_reg        <= pp_next;
            key_reg       <= key_next;
            ph_reg        <= ph_next;
            hcnt_reg      <= hcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_byte_reg <= pend_byte_next;
        hb0_reg       <= hb0_next;
        hb1_reg       <= hb1_next;
    end

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> (state_reg == acp_pkg::ST_IDLE))
        else $error("command taken while engine busy");

    a_cur_enc: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> (state_reg == acp_pkg::ST_ENC))
        else $error("encrypt work pending outside encrypt state");

    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acp_pkg::ST_IDLE) |-> (pend_reg == '0))
        else $error("letters left behind at end of item");

endmodule

@@ dv/tb_autokey_letter_pair_cipher_core.sv @@
`timescale 1ns / 1ps

module tb_autokey_letter_pair_cipher_core;

    localparam int IDLE_WAIT = 200;
    localparam int STALL_LIMIT = 20000;

    // Expected-letter store and cipher predictor.
    class cipher_scoreboard;
        logic [15:0] mult_k;
        logic [15:0] add_k;
        logic [15:0] seed_key[3];
        bit          decrypt;
        logic [15:0] key[3];
        logic [7:0]  hi_letter[3];
        bit          hi_waiting[3];
        logic [7:0]  held[3][2];
        int          held_cnt[3];
        acp_pkg::result_t pending[$];
        int          errors;
        logic [7:0]  letters[$];

        function new();
            mult_k = acp_pkg::MULT_DEFAULT;
            add_k = acp_pkg::ADD_DEFAULT;
            seed_key[0] = 16'd62153;
            seed_key[1] = 16'd42536;
            seed_key[2] = 16'd21354;
            decrypt = 0;
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int l = 0; l < 3; l++)
            begin
                key[l] = seed_key[l];
                hi_waiting[l] = 0;
                held_cnt[l] = 0;
            end
        endfunction

        function logic [15:0] advance_key(logic [7:0] c, logic [15:0] k);
            logic [31:0] s;
            s = ((32'(c) + 32'(k)) * 32'(mult_k) + 32'(add_k));
            return s[15:0];
        endfunction

        function void write_reg(int idx, logic [31:0] v);
            case (idx)
                acp_pkg::REG_MULT: mult_k = (v[15:0] == 0) ? acp_pkg::MULT_DEFAULT : v[15:0];
                acp_pkg::REG_ADD: add_k = (v[15:0] == 0) ? acp_pkg::ADD_DEFAULT : v[15:0];
                acp_pkg::REG_KEY0: seed_key[0] = v[15:0];
                acp_pkg::REG_KEY1: seed_key[1] = v[15:0];
                acp_pkg::REG_KEY2: seed_key[2] = v[15:0];
                acp_pkg::REG_DECRYPT: decrypt = v[0];
                default: ;
            endcase
            restart();
        endfunction

        // Encrypt one byte at layer l; letters out of the outer layer land in letters.
        function void encrypt_feed(int l, logic [7:0] b);
            logic [7:0] c;
            if (l >= 3)
            begin
                letters.push_back(b);
                return;
            end
            c = b ^ key[l][15:8];
            key[l] = advance_key(c, key[l]);
            encrypt_feed(l + 1, 8'(65 + c / 26));
            encrypt_feed(l + 1, 8'(65 + c % 26));
        endfunction

        function bit decrypt_feed(logic [7:0] v, output logic [7:0] b);
            logic [7:0] j;
            logic [7:0] p;
            for (int l = 2; l >= 0; l--)
            begin
                if (!hi_waiting[l])
                begin
                    hi_letter[l] = v;
                    hi_waiting[l] = 1;
                    return 0;
                end
                hi_waiting[l] = 0;
                j = 8'((32'(hi_letter[l]) - 65) * 26 + (32'(v) - 65));
                p = j ^ key[l][15:8];
                key[l] = advance_key(j, key[l]);
                if (held_cnt[l] < 2)
                begin
                    held[l][held_cnt[l]] = p;
                    held_cnt[l]++;
                    return 0;
                end
                v = held[l][0];
                held[l][0] = held[l][1];
                held[l][1] = p;
            end
            b = v;
            return 1;
        endfunction

        // Note an accepted item and queue what it should produce.
        function void note_item(acp_pkg::request_t rq);
            acp_pkg::result_t r;
            logic [7:0] b;
            if (decrypt)
            begin
                if (decrypt_feed(rq.data_in, b))
                begin
                    r.data_out = b;
                    r.last_out = rq.end_of_message;
                    r.no_data = 0;
                    pending.push_back(r);
                end
                else if (rq.end_of_message)
                begin
                    r = '{8'd0, 1'b1, 1'b1};
                    pending.push_back(r);
                end
                if (rq.end_of_message)
                    restart();
                return;
            end
            letters.delete();
            encrypt_feed(0, rq.data_in);
            if (rq.end_of_message)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    encrypt_feed(l, acp_pkg::LETTER_P);
                    encrypt_feed(l, acp_pkg::LETTER_C);
                end
                restart();
            end
            foreach (letters[k])
            begin
                r.data_out = letters[k];
                r.last_out = rq.end_of_message && (k == letters.size() - 1);
                r.no_data = 0;
                pending.push_back(r);
            end
        endfunction

        function void check_result(acp_pkg::result_t got);
            acp_pkg::result_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected result data_out=%0d", got.data_out);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.data_out !== want.data_out)
            begin
                $error("data_out expected %0d actual %0d", want.data_out, got.data_out);
                errors++;
            end
            if (got.last_out !== want.last_out)
            begin
                $error("last_out expected %0d actual %0d", want.last_out, got.last_out);
                errors++;
            end
            if (got.no_data !== want.no_data)
            begin
                $error("no_data expected %0d actual %0d", want.no_data, got.no_data);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        push = 0;
    logic        full;
    acp_pkg::request_t request = '0;
    logic        empty;
    logic        pop = 0;
    acp_pkg::result_t  result;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cipher_scoreboard sb;
    int  quiet_cycles = 0;
    bit  drain_hold = 0;   // long receiver hold-off while the sender keeps pushing
    bit  pop_busy = 1;     // random idling on the result side

    always #10 clk = ~clk;

    autokey_letter_pair_cipher_core DUT (
        .clk(clk), .rst_n(rst_n),
        .push(push), .full(full), .request(request),
        .empty(empty), .pop(pop), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Sample both handshakes at the rising edge; watchdog counts idle cycles.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (push && !full)
                sb.note_item(request);
            if (pop && !empty)
                sb.check_result(result);
            if (quiet_cycles > STALL_LIMIT)
            begin
                $display("tb_autokey_letter_pair_cipher_core: FAIL");
                $finish;
            end
        end
    end

    // Receiver: random pops with mostly short gaps and occasional long ones.
    always @(negedge clk)
    begin
        if (drain_hold)
            pop <= 0;
        else if (!pop_busy)
            pop <= 1;
        else
            case ($urandom_range(0, 19))
                0: pop <= ($urandom_range(0, 40) == 0);
                1, 2, 3: pop <= 0;
                default: pop <= 1;
            endcase
    end

    // Push stays high from one item to the next when there is no gap.
    task automatic send_item(logic [7:0] d, logic e);
        int gap;
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            push <= 0;
            repeat (gap) @(negedge clk);
        end
        push <= 1;
        request <= '{d, e};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop push, wait until all expected results have come, then let the block settle.
    task automatic settle();
        push <= 0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(acp_pkg::reg_index_t idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1;
        pwrite <= 1;
        paddr <= 5'(4 * idx);
        pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(posedge clk);
        sb.write_reg(idx, v);
        @(negedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    // Plaintext message of random bytes.
    task automatic send_plain(int len);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    // Decrypt message: mostly valid letters, sometimes any code, odd lengths too.
    task automatic send_letters(int len, bit noisy);
        logic [7:0] d;
        for (int i = 0; i < len; i++)
        begin
            d = noisy && $urandom_range(0, 3) == 0 ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(65, 90));
            send_item(d, i == len - 1);
        end
    endtask

    int sent;

    initial
    begin
        sb = new();
        repeat (4) @(negedge clk);
        rst_n = 1;

        // Directed: extreme bytes, message ends alone and back to back.
        send_item(8'd0, 0);
        send_item(8'd255, 1);
        send_item(8'd25, 1);
        send_item(8'd26, 0);
        send_item(8'd170, 0);
        send_item(8'd85, 1);
        settle();

        // Extreme constants: zero writes select defaults, all ones, zero keys.
        write_reg(acp_pkg::REG_MULT, 32'd0);
        write_reg(acp_pkg::REG_ADD, 32'hFFFF_FFFF);
        write_reg(acp_pkg::REG_KEY0, 32'd0);
        write_reg(acp_pkg::REG_KEY1, 32'hFFFF);
        write_reg(acp_pkg::REG_KEY2, 32'd0);
        send_plain(2);
        settle();
        write_reg(acp_pkg::REG_MULT, 32'hFFFF);
        write_reg(acp_pkg::REG_ADD, 32'd0);
        send_plain(1);
        settle();

        // Directed decrypt: short messages, odd trailing letter, non-letter codes.
        write_reg(acp_pkg::REG_DECRYPT, 32'd1);
        send_item(8'd65, 1);
        send_item(8'd90, 0);
        send_item(8'd65, 1);
        send_item(8'd0, 0);
        send_item(8'd255, 0);
        send_item(8'd90, 0);
        send_item(8'd90, 0);
        send_item(8'd65, 0);
        send_item(8'd65, 0);
        send_item(8'd77, 1);
        send_letters(17, 0);
        settle();

        // Random phases alternating modes and constants.
        sent = 0;
        for (int ph = 0; sent < 200; ph++)
        begin
            if (ph % 2 == 0)
            begin
                write_reg(acp_pkg::REG_DECRYPT, 32'd0);
                write_reg(acp_pkg::REG_MULT, $urandom);
                write_reg(acp_pkg::REG_ADD, $urandom);
                write_reg(acp_pkg::REG_KEY0, $urandom);
                write_reg(acp_pkg::REG_KEY1, $urandom);
                write_reg(acp_pkg::REG_KEY2, $urandom);
                if (ph == 2)
                    drain_hold = 1;   // fill the block while results are held
                for (int m = 0; m < 4; m++)
                begin
                    int len;
                    len = $urandom_range(1, 6);
                    send_plain(len);
                    sent += len;
                end
            end
            else
            begin
                write_reg(acp_pkg::REG_DECRYPT, 32'd1);
                for (int m = 0; m < 4; m++)
                begin
                    int len;
                    len = $urandom_range(1, 40);
                    send_letters(len, m == 3);
                    sent += len;
                end
            end
            settle();
        end
        settle();

        if (sb.errors == 0)
            $display("tb_autokey_letter_pair_cipher_core: PASS");
        else
            $display("tb_autokey_letter_pair_cipher_core: FAIL");
        $finish;
    end

    // Long receiver hold-off, counted here, released after a fixed stretch.
    initial
    begin
        wait (drain_hold);
        repeat (3000) @(negedge clk);
        drain_hold = 0;
    end

    // Stretches with no idling on the result side.
    initial
    begin
        forever
        begin
            repeat ($urandom_range(100, 600)) @(negedge clk);
            pop_busy = ~pop_busy;
        end
    end

endmodule

@@ sim.f @@
rtl/acp_pkg.sv
rtl/acp_fifo.sv
rtl/acp_front.sv
rtl/acp_back.sv
rtl/autokey_letter_pair_cipher_core.sv
dv/tb_autokey_letter_pair_cipher_core.sv
